@@ sv/otp_pkg.sv @@
package otp_pkg;

  // cell classes
  localparam logic [1:0] CLS_FREE = 2'd0;
  localparam logic [1:0] CLS_OBST = 2'd1;
  localparam logic [1:0] CLS_PAD  = 2'd2;

  // operations
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_PAD    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_PAD_CELLS = 2'd1;
  localparam logic [1:0] CFG_GRID_ROWS = 2'd2;
  localparam logic [1:0] CFG_GRID_COLS = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COUNT_W    = 17;

  typedef logic [1:0] cls_t;

endpackage

@@ sv/otp_if.sv @@
interface otp_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [7:0]        cell_row;
  logic [7:0]        cell_col;
  logic signed [7:0] raw_occupancy;
  logic [8:0]        region_row_min;
  logic [8:0]        region_row_end;
  logic [8:0]        region_col_min;
  logic [8:0]        region_col_end;

  modport source (
    output valid, operation, cell_row, cell_col, raw_occupancy,
           region_row_min, region_row_end, region_col_min, region_col_end,
    input  ready
  );
  modport sink (
    input  valid, operation, cell_row, cell_col, raw_occupancy,
           region_row_min, region_row_end, region_col_min, region_col_end,
    output ready
  );
endinterface

interface otp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cell_class;
  logic [16:0] cells_padded;

  modport source (output valid, cell_class, cells_padded, input ready);
  modport sink (input valid, cell_class, cells_padded, output ready);
endinterface

@@ sv/occupancy_threshold_and_pad_top.sv @@
// A write's result is registered in the cycle after the write is taken; a read goes
// through ST_RDW (one grid memory read) before its result is registered.
// A pad sweep reads each swept cell and, if it is free, its neighbors up to the first
// non-free one, then commits each cell in a second pass. One transaction at a time;
// writes sustain one per cycle if out_ch.ready. Reset: rst_n is synchronous; a clearing
// pass then frees every cell and clears every mark; no input is taken until it ends.
module occupancy_threshold_and_pad_top #(
  parameter int MAX_DIM = 256,
  parameter int MAX_PAD = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [otp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [otp_pkg::CFG_DATA_W-1:0]    cfg_data,
  otp_in_if.sink                            in_ch,
  otp_out_if.source                         out_ch
);

  localparam int IW    = $clog2(MAX_DIM);
  localparam int XW    = IW + 1;
  localparam int AW    = 2 * IW;
  localparam int SW    = (IW + 3 > 11) ? IW + 3 : 11;
  localparam int PUW   = $clog2(MAX_PAD + 1);
  localparam int PW    = PUW + 1;
  localparam int DEPTH = 1 << AW;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RDW    = 4'd2;
  localparam logic [3:0] ST_P1C_RD = 4'd3;
  localparam logic [3:0] ST_P1C_EV = 4'd4;
  localparam logic [3:0] ST_P1N_RD = 4'd5;
  localparam logic [3:0] ST_P1N_EV = 4'd6;
  localparam logic [3:0] ST_P2_RD  = 4'd7;
  localparam logic [3:0] ST_P2_EV  = 4'd8;

  // configuration
  logic signed [7:0] thr_r;
  logic [2:0]        pad_r;
  logic [8:0]        rows_r, cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 8'sd50;
      pad_r  <= 3'd1;
      rows_r <= 9'd256;
      cols_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        otp_pkg::CFG_THRESHOLD: thr_r  <= $signed(cfg_data[7:0]);
        otp_pkg::CFG_PAD_CELLS: pad_r  <= cfg_data[2:0];
        otp_pkg::CFG_GRID_ROWS: rows_r <= cfg_data;
        otp_pkg::CFG_GRID_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective dimensions and radius
  logic [SW-1:0]        h_u, w_u;
  logic [PUW-1:0]       pe;
  logic signed [SW-1:0] h_s, w_s, p_s;
  logic signed [PW-1:0] p_n;

  always_comb begin
    h_u = (SW'(rows_r) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(rows_r);
    w_u = (SW'(cols_r) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(cols_r);
    pe  = (8'(pad_r) > 8'(MAX_PAD)) ? PUW'(MAX_PAD) : PUW'(pad_r);
    h_s = $signed(h_u);
    w_s = $signed(w_u);
    p_s = $signed(SW'(pe));
    p_n = $signed({1'b0, pe});
  end

  // state
  logic [3:0]                   state_r, state_nxt;
  logic [AW:0]                  clr_r;
  logic [XW-1:0]                i_r, j_r, i0_r, i1_r, j0_r, j1_r;
  logic signed [PW-1:0]         di_r, dj_r;
  logic [otp_pkg::COUNT_W-1:0]  cnt_r;
  logic                         in_grid_r;
  logic                         out_v_r;
  logic [1:0]                   out_cls_r;
  logic [otp_pkg::COUNT_W-1:0]  out_cnt_r;

  // memories
  otp_pkg::cls_t grid_mem [DEPTH];
  logic          mark_mem [DEPTH];
  otp_pkg::cls_t g_rd_r;
  logic          m_rd_r;
  logic          g_we, m_we, m_wd;
  logic [AW-1:0] g_wa, g_ra, m_wa, m_ra;
  otp_pkg::cls_t g_wd;

  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_wa] <= g_wd;
    g_rd_r <= grid_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (m_we) mark_mem[m_wa] <= m_wd;
    m_rd_r <= mark_mem[m_ra];
  end

  // input decode
  logic                 in_acc;
  logic                 in_grid;
  logic [AW-1:0]        in_addr, cur_addr, nb_addr;
  otp_pkg::cls_t        wr_cls;
  logic signed [SW-1:0] rmin_s, rend_s, cmin_s, cend_s;
  logic signed [SW-1:0] i0_s, i1_s, j0_s, j1_s, ni_s, nj_s;
  logic                 sweep_empty;
  logic [SW-1:0]        row_x, col_x;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_v_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    row_x   = SW'(in_ch.cell_row);
    col_x   = SW'(in_ch.cell_col);
    in_grid = (row_x < h_u) && (col_x < w_u);
    in_addr = {row_x[IW-1:0], col_x[IW-1:0]};
    wr_cls  = (in_ch.raw_occupancy > thr_r) ? otp_pkg::CLS_OBST : otp_pkg::CLS_FREE;
    rmin_s  = $signed(SW'(in_ch.region_row_min));
    rend_s  = $signed(SW'(in_ch.region_row_end));
    cmin_s  = $signed(SW'(in_ch.region_col_min));
    cend_s  = $signed(SW'(in_ch.region_col_end));
    i0_s    = (rmin_s - p_s > p_s) ? rmin_s - p_s : p_s;
    i1_s    = (rend_s + p_s < h_s - p_s) ? rend_s + p_s : h_s - p_s;
    j0_s    = (cmin_s - p_s > p_s) ? cmin_s - p_s : p_s;
    j1_s    = (cend_s + p_s < w_s - p_s) ? cend_s + p_s : w_s - p_s;
    sweep_empty = (i1_s <= i0_s) || (j1_s <= j0_s);
    cur_addr = {i_r[IW-1:0], j_r[IW-1:0]};
    ni_s    = $signed(SW'(i_r)) + SW'(di_r);
    nj_s    = $signed(SW'(j_r)) + SW'(dj_r);
    nb_addr = {ni_s[IW-1:0], nj_s[IW-1:0]};
  end

  // sweep stepping
  logic          last_j, last_i, last_dj, last_di;
  logic [XW-1:0] j_inc, i_inc;

  always_comb begin
    j_inc   = j_r + XW'(1);
    i_inc   = i_r + XW'(1);
    last_j  = (j_inc == j1_r);
    last_i  = (i_inc == i1_r);
    last_dj = (dj_r == p_n);
    last_di = (di_r == p_n);
  end

  // memory port steering
  always_comb begin
    g_we = 1'b0;
    g_wa = in_addr;
    g_wd = wr_cls;
    m_we = 1'b0;
    m_wa = cur_addr;
    m_wd = 1'b0;
    g_ra = in_addr;
    m_ra = cur_addr;
    unique case (state_r)
      ST_CLR: begin
        g_we = 1'b1;
        g_wa = clr_r[AW-1:0];
        g_wd = otp_pkg::CLS_FREE;
        m_we = 1'b1;
        m_wa = clr_r[AW-1:0];
      end
      ST_IDLE: begin
        g_we = in_acc && (in_ch.operation == otp_pkg::OP_WRITE) && in_grid;
      end
      ST_P1C_RD: g_ra = cur_addr;
      ST_P1N_RD: g_ra = nb_addr;
      ST_P1N_EV: begin
        m_we = (g_rd_r != otp_pkg::CLS_FREE);
        m_wd = 1'b1;
      end
      ST_P2_EV: begin
        g_we = m_rd_r;
        g_wa = cur_addr;
        g_wd = otp_pkg::CLS_PAD;
        m_we = m_rd_r;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:    if (clr_r[AW-1:0] == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == otp_pkg::OP_READ) state_nxt = ST_RDW;
          else if (in_ch.operation == otp_pkg::OP_PAD && !sweep_empty)
            state_nxt = ST_P1C_RD;
        end
      end
      ST_RDW:    state_nxt = ST_IDLE;
      ST_P1C_RD: state_nxt = ST_P1C_EV;
      ST_P1C_EV: begin
        if (g_rd_r == otp_pkg::CLS_FREE) state_nxt = ST_P1N_RD;
        else if (last_j && last_i) state_nxt = ST_P2_RD;
        else state_nxt = ST_P1C_RD;
      end
      ST_P1N_RD: state_nxt = ST_P1N_EV;
      ST_P1N_EV: begin
        if (g_rd_r != otp_pkg::CLS_FREE || (last_dj && last_di)) begin
          if (last_j && last_i) state_nxt = ST_P2_RD;
          else state_nxt = ST_P1C_RD;
        end else begin
          state_nxt = ST_P1N_RD;
        end
      end
      ST_P2_RD:  state_nxt = ST_P2_EV;
      ST_P2_EV:  state_nxt = (last_j && last_i) ? ST_IDLE : ST_P2_RD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + (AW + 1)'(1);
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (state_r == ST_IDLE && in_acc &&
          (in_ch.operation != otp_pkg::OP_READ) &&
          !(in_ch.operation == otp_pkg::OP_PAD && !sweep_empty))
        out_v_r <= 1'b1;
      if (state_r == ST_RDW) out_v_r <= 1'b1;
      if (state_r == ST_P2_EV && last_j && last_i) out_v_r <= 1'b1;
    end
  end

  // datapath registers
  logic advance;
  always_comb begin
    advance = (state_r == ST_P2_EV) ||
              (state_r == ST_P1C_EV && g_rd_r != otp_pkg::CLS_FREE) ||
              (state_r == ST_P1N_EV &&
               (g_rd_r != otp_pkg::CLS_FREE || (last_dj && last_di)));
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      in_grid_r <= in_grid;
      i0_r      <= XW'(i0_s);
      i1_r      <= XW'(i1_s);
      j0_r      <= XW'(j0_s);
      j1_r      <= XW'(j1_s);
      i_r       <= XW'(i0_s);
      j_r       <= XW'(j0_s);
      cnt_r     <= '0;
      out_cls_r <= (in_ch.operation == otp_pkg::OP_WRITE && in_grid) ? wr_cls
                                                                    : otp_pkg::CLS_FREE;
      out_cnt_r <= '0;
    end
    if (state_r == ST_RDW) begin
      out_cls_r <= in_grid_r ? g_rd_r : otp_pkg::CLS_FREE;
      out_cnt_r <= '0;
    end
    // start the neighbor scan at the top-left corner
    if (state_r == ST_P1C_EV && g_rd_r == otp_pkg::CLS_FREE) begin
      di_r <= -p_n;
      dj_r <= -p_n;
    end
    if (state_r == ST_P1N_EV && !advance) begin
      if (last_dj) begin
        dj_r <= -p_n;
        di_r <= di_r + PW'(1);
      end else begin
        dj_r <= dj_r + PW'(1);
      end
    end
    // step to the next cell; wrap to the first cell between the two passes
    if (advance) begin
      if (last_j) begin
        j_r <= j0_r;
        i_r <= last_i ? i0_r : i_inc;
      end else begin
        j_r <= j_inc;
      end
    end
    if (state_r == ST_P2_EV) begin
      if (m_rd_r) cnt_r <= cnt_r + otp_pkg::COUNT_W'(1);
      if (last_j && last_i) begin
        out_cls_r <= otp_pkg::CLS_FREE;
        out_cnt_r <= cnt_r + otp_pkg::COUNT_W'(m_rd_r);
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.cell_class   = out_cls_r;
  assign out_ch.cells_padded = out_cnt_r;

  // checks
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !out_v_r) else $error("result during clearing pass");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == ST_IDLE)) else $error("ready outside idle");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.operation == otp_pkg::OP_WRITE) |=> out_v_r)
    else $error("write gave no result");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.operation == otp_pkg::OP_READ) |=> ##1 out_v_r)
    else $error("read gave no result");

endmodule
